// ===== hdl/cfa_pkg.sv =====
// package: payload types and constants for the contiguous fit allocator
`default_nettype none
package cfa_pkg;

  localparam int MemUnits = 1024;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [10:0] run_length;
    logic [9:0]  free_start;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [9:0]  block_start;
    logic [9:0]  hole_count;
    logic [10:0] used_units;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/contiguous_fit_allocator_core.sv =====
// top level: bitmap allocator with first, best, worst and next fit search
//
// usage: one command beat is taken when start is high and busy is low.
// a free beat clears run_length units from free_start, an allocate beat
// searches the occupancy map under the fit_mode register and marks a run.
// one result beat per command appears on out_item for exactly one cycle,
// flagged by out_valid; the receiver cannot stall it.
// the map is a one-bit-wide memory read with registered data, one unit per
// cycle, feeding the shared hole tracker; a used-unit counter follows it.
// allocate scans from unit 0 (from the rover in next fit) to the map end,
// picks the hole, marks run_length units of it when granted and loads the
// result. free clears n units (run_length clipped at the map end), then
// loads the result.
// busy stays high until out_valid; the next command can be taken at the
// edge that ends the out_valid cycle.
// reset is synchronous; after it a clearing pass writes every map unit
// free with busy high. cfg writes are taken any time and
// should only be issued while idle.
`default_nettype none
module contiguous_fit_allocator_core #(
  parameter int MEM_UNITS = cfa_pkg::MemUnits
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  cfa_pkg::in_item_t   in_item,
  output logic                out_valid,
  output cfa_pkg::out_item_t  out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_fit_mode
);

  localparam int AW = $clog2(MEM_UNITS);
  // wide enough for free_start + run_length and for a unit count
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_PICK  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic                 map_mem [MEM_UNITS];
  logic                 rd_bit_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_addr_r;
  logic [1:0]           mode_r;
  logic [AW-1:0]        rover_r;
  logic [CW-1:0]        used_r;
  logic [CW-1:0]        idx_r;      // clear / scan / mark / free position
  logic [10:0]          len_r;
  logic                 kind_r;
  // hole tracking
  logic                 in_hole_r;
  logic [AW-1:0]        hstart_r;
  logic [CW-1:0]        hlen_r;
  logic                 have_r;
  logic [AW-1:0]        pick_r;
  logic [CW-1:0]        plen_r;
  logic [9:0]           holes_r;
  logic [CW-1:0]        left_r;     // units still to mark or clear
  cfa_pkg::out_item_t   res_r;
  logic                 ovalid_r;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_item  = res_r;

  // the tracker sees one read unit per cycle; past the map end it sees a used unit
  logic          idx_lt_end, scan_end, trk_step, bit_used, close_hole;
  logic          take, grant;
  logic [CW-1:0] len_ext;
  // map port controls
  logic          rd_en, wr_en, wr_bit;
  logic [AW-1:0] wr_addr;

  assign len_ext    = CW'(len_r);
  assign idx_lt_end = (idx_r < CW'(MEM_UNITS));
  assign scan_end   = !rd_vld_r && !idx_lt_end;
  assign trk_step   = (state_r == S_SCAN) && (rd_vld_r || scan_end);
  assign bit_used   = rd_vld_r ? rd_bit_r : 1'b1;
  assign close_hole = in_hole_r && bit_used;
  assign grant      = have_r && (len_r != 11'd0) && (plen_r >= len_ext);

  always_comb begin
    take = 1'b0;
    case (mode_r)
      cfa_pkg::FIT_WORST: take = !have_r || (hlen_r > plen_r);
      cfa_pkg::FIT_BEST:  take = (hlen_r >= len_ext) && (!have_r || hlen_r < plen_r);
      default:            take = (hlen_r >= len_ext) && !have_r;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_bit  = 1'b0;
    wr_addr = idx_r[AW-1:0];
    case (state_r)
      S_CLEAR: wr_en = 1'b1;
      S_SCAN:  rd_en = idx_lt_end;
      S_MARK: begin
        wr_en  = 1'b1;
        wr_bit = 1'b1;
      end
      // read one unit ahead, clear the unit read the cycle before
      S_FREE: begin
        rd_en   = (left_r != '0) && idx_lt_end;
        wr_en   = rd_vld_r;
        wr_addr = rd_addr_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (idx_r == CW'(MEM_UNITS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) begin
        state_nxt = (in_item.kind == cfa_pkg::KIND_FREE) ? S_FREE : S_SCAN;
      end
      S_SCAN:  if (scan_end) state_nxt = S_PICK;
      S_PICK:  state_nxt = grant ? S_MARK : S_DONE;
      S_MARK:  if (left_r == CW'(1)) state_nxt = S_DONE;
      S_FREE:  if (!rd_en) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // occupancy map: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_bit;
    if (rd_en) rd_bit_r <= map_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      idx_r    <= '0;
      mode_r   <= cfa_pkg::FIT_FIRST;
      rover_r  <= '0;
      used_r   <= '0;
      ovalid_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= (state_r == S_DONE);
      rd_vld_r  <= rd_en;
      rd_addr_r <= idx_r[AW-1:0];
      if (cfg_valid && cfg_ready) mode_r <= cfg_fit_mode;
      case (state_r)
        S_CLEAR: idx_r <= idx_r + CW'(1);
        S_IDLE: if (start) begin
          kind_r    <= in_item.kind;
          len_r     <= in_item.run_length;
          in_hole_r <= 1'b0;
          have_r    <= 1'b0;
          holes_r   <= '0;
          pick_r    <= '0;
          plen_r    <= '0;
          hlen_r    <= '0;
          if (in_item.kind == cfa_pkg::KIND_FREE) begin
            idx_r  <= CW'(in_item.free_start);
            left_r <= CW'(in_item.run_length);
          end else begin
            idx_r  <= (mode_r == cfa_pkg::FIT_NEXT) ? CW'(rover_r) : '0;
          end
        end
        S_SCAN: begin
          if (rd_en) idx_r <= idx_r + CW'(1);
          if (trk_step) begin
            if (close_hole && take) begin
              have_r <= 1'b1;
              pick_r <= hstart_r;
              plen_r <= hlen_r;
            end
            if (!bit_used) begin
              if (!in_hole_r) begin
                in_hole_r <= 1'b1;
                hstart_r  <= rd_addr_r;
                hlen_r    <= CW'(1);
                holes_r   <= holes_r + 10'd1;
              end else begin
                hlen_r <= hlen_r + CW'(1);
              end
            end else begin
              in_hole_r <= 1'b0;
            end
          end
        end
        // the picked hole is all free, so the count grows by the full run
        S_PICK: begin
          idx_r  <= CW'(pick_r);
          left_r <= len_ext;
          if (grant) used_r <= used_r + len_ext;
        end
        S_MARK: begin
          idx_r  <= idx_r + CW'(1);
          left_r <= left_r - CW'(1);
        end
        S_FREE: begin
          if (rd_en) begin
            idx_r  <= idx_r + CW'(1);
            left_r <= left_r - CW'(1);
          end
          if (rd_vld_r && rd_bit_r) used_r <= used_r - CW'(1);
        end
        S_DONE: begin
          res_r.used_units <= 11'(used_r);
          if (kind_r == cfa_pkg::KIND_FREE) begin
            rover_r <= '0;
            res_r.granted     <= 1'b1;
            res_r.block_start <= '0;
            res_r.hole_count  <= '0;
          end else begin
            res_r.hole_count <= holes_r;
            if (grant) begin
              rover_r <= pick_r;
              res_r.granted     <= 1'b1;
              res_r.block_start <= 10'(pick_r);
            end else begin
              res_r.granted     <= 1'b0;
              res_r.block_start <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result beat missing");
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MEM_UNITS)) else $error("used count overflow");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy during result beat");
`endif

endmodule
`default_nettype wire
